// File: design/ipv4p_pkg.sv
`default_nettype none
package ipv4p_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 65536;
  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [7:0] LINK_OFFSET_RESET = 8'd14;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [5:0] MIN_IP_BYTES = 6'd20;
  localparam logic [5:0] MIN_TCP_BYTES = 6'd20;
  localparam logic [5:0] UDP_BYTES = 6'd8;
  localparam logic [15:0] PAYLOAD_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_TCP_OK      = 3'd0,
    ST_UDP_OK      = 3'd1,
    ST_SHORT_LINK  = 3'd2,
    ST_SHORT_IP    = 3'd3,
    ST_BAD_IHL     = 3'd4,
    ST_OTHER_PROTO = 3'd5,
    ST_SHORT_TCP   = 3'd6,
    ST_SHORT_UDP   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TCP  = 2'd1,
    KIND_UDP  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [POS_W-1:0] total;
    logic [7:0]       link_offset;
    logic [5:0]       hdr_bytes;
    kind_t            kind;
    logic [5:0]       tcp_bytes;
    logic [3:0]       version;
    logic [7:0]       service;
    logic [12:0]      fragment;
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
    logic [31:0]      ports;
    logic [31:0]      seq;
    logic [31:0]      ack;
    logic [5:0]       flags;
  } frame_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  version;
    logic [5:0]  hdr_bytes;
    logic [7:0]  service;
    logic [12:0] fragment;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ports;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [5:0]  flags;
    logic [15:0] payload;
  } result_t;

endpackage
`default_nettype wire

// File: design/ipv4p_judge.sv
`default_nettype none
module ipv4p_judge (
  input  ipv4p_pkg::frame_t  frame,
  output ipv4p_pkg::result_t result
);
  import ipv4p_pkg::*;

  logic [POS_W-1:0] ip_rest;
  logic [POS_W-1:0] l4_rest;
  logic [POS_W-1:0] payload_raw;
  logic [15:0]      payload_sat;
  status_t          status;

  always_comb begin
    ip_rest = frame.total - POS_W'(frame.link_offset);
    l4_rest = ip_rest - POS_W'(frame.hdr_bytes);
    if (frame.kind == KIND_TCP) begin
      payload_raw = l4_rest - POS_W'(frame.tcp_bytes);
    end else begin
      payload_raw = l4_rest - POS_W'(UDP_BYTES);
    end
    payload_sat = (payload_raw > POS_W'(PAYLOAD_MAX)) ? PAYLOAD_MAX : payload_raw[15:0];
  end

  always_comb begin
    priority if (frame.total < POS_W'(frame.link_offset)) begin
      status = ST_SHORT_LINK;
    end else if (ip_rest < POS_W'(MIN_IP_BYTES)) begin
      status = ST_SHORT_IP;
    end else if (frame.hdr_bytes < MIN_IP_BYTES) begin
      status = ST_BAD_IHL;
    end else if (ip_rest < POS_W'(frame.hdr_bytes)) begin
      status = ST_SHORT_IP;
    end else if (frame.kind == KIND_TCP) begin
      if (l4_rest < POS_W'(MIN_TCP_BYTES) || l4_rest < POS_W'(frame.tcp_bytes)) begin
        status = ST_SHORT_TCP;
      end else begin
        status = ST_TCP_OK;
      end
    end else if (frame.kind == KIND_UDP) begin
      if (l4_rest < POS_W'(UDP_BYTES)) begin
        status = ST_SHORT_UDP;
      end else begin
        status = ST_UDP_OK;
      end
    end else begin
      status = ST_OTHER_PROTO;
    end
  end

  always_comb begin
    result = '0;
    result.status = status;
    if (status == ST_TCP_OK || status == ST_UDP_OK) begin
      result.version   = frame.version;
      result.hdr_bytes = frame.hdr_bytes;
      result.service   = frame.service;
      result.fragment  = frame.fragment;
      result.src_addr  = frame.src_addr;
      result.dst_addr  = frame.dst_addr;
      result.ports     = frame.ports;
      result.payload   = payload_sat;
      if (status == ST_TCP_OK) begin
        result.seq   = frame.seq;
        result.ack   = frame.ack;
        result.flags = frame.flags;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/ipv4_tcp_udp_header_parser.sv
`default_nettype none
// Parses one frame byte per cycle: skips cfg_data link-header bytes, captures the IPv4
// header and the TCP or UDP header, and after the byte flagged last_byte delivers one
// result beat with a status code and the payload length. Bytes are taken back to back;
// the result passes through a frame-snapshot register, then the result register holding
// the status decode. in_ready drops only while both the snapshot and the result register
// are full and out_ready is low. Frames longer than 65536 bytes are counted as 65536
// bytes.
module ipv4_tcp_udp_header_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [3:0]       ip_version,
  output logic [5:0]       ip_header_bytes,
  output logic [7:0]       service_type,
  output logic [12:0]      fragment_offset,
  output logic [31:0]      src_address,
  output logic [31:0]      dst_address,
  output logic [31:0]      port_pair,
  output logic [31:0]      sequence_number,
  output logic [31:0]      acknowledge_number,
  output logic [5:0]       tcp_flag_bits,
  output logic [15:0]      payload_length
);
  import ipv4p_pkg::*;

  logic [7:0]       link_offset;
  logic [POS_W-1:0] byte_position;
  frame_t           cur;
  frame_t           cap;

  frame_t           snap;
  logic             snap_valid;
  logic             snap_adv;
  result_t          res;
  result_t          res_next;

  logic             accept;
  logic             pos_live;
  logic             in_ip;
  logic [POS_W-1:0] ip_idx;
  logic [5:0]       hl_eff;
  logic [POS_W-1:0] l4_idx;
  logic             in_l4;

  assign accept   = in_valid && in_ready;
  assign snap_adv = snap_valid && (!out_valid || out_ready);
  assign in_ready = !snap_valid || snap_adv;

  always_comb begin
    pos_live = byte_position < POS_W'(MAX_FRAME_BYTES);
    in_ip    = byte_position >= POS_W'(link_offset);
    ip_idx   = byte_position - POS_W'(link_offset);
    cap      = cur;
    cap.link_offset = link_offset;
    cap.total = pos_live ? byte_position + POS_W'(1) : byte_position;

    if (pos_live && in_ip) begin
      unique case (1'b1)
        ip_idx == POS_W'(0): begin
          cap.version   = data_byte[7:4];
          cap.hdr_bytes = {data_byte[3:0], 2'b00};
        end
        ip_idx == POS_W'(1): cap.service = data_byte;
        ip_idx == POS_W'(6): cap.fragment = {data_byte[4:0], cur.fragment[7:0]};
        ip_idx == POS_W'(7): cap.fragment = {cur.fragment[12:8], data_byte};
        ip_idx == POS_W'(9): begin
          if (data_byte == PROTO_TCP) begin
            cap.kind = KIND_TCP;
          end else if (data_byte == PROTO_UDP) begin
            cap.kind = KIND_UDP;
          end else begin
            cap.kind = KIND_NONE;
          end
        end
        ip_idx >= POS_W'(12) && ip_idx < POS_W'(16):
          cap.src_addr = {cur.src_addr[23:0], data_byte};
        ip_idx >= POS_W'(16) && ip_idx < POS_W'(20):
          cap.dst_addr = {cur.dst_addr[23:0], data_byte};
        default: ;
      endcase
    end

    hl_eff = cap.hdr_bytes;
    l4_idx = ip_idx - POS_W'(hl_eff);
    in_l4  = pos_live && in_ip && (hl_eff >= MIN_IP_BYTES) && (ip_idx >= POS_W'(hl_eff));

    if (in_l4) begin
      unique case (cap.kind)
        KIND_TCP: begin
          if (l4_idx < POS_W'(4)) begin
            cap.ports = {cur.ports[23:0], data_byte};
          end else if (l4_idx < POS_W'(8)) begin
            cap.seq = {cur.seq[23:0], data_byte};
          end else if (l4_idx < POS_W'(12)) begin
            cap.ack = {cur.ack[23:0], data_byte};
          end else if (l4_idx == POS_W'(12)) begin
            cap.tcp_bytes = {data_byte[7:4], 2'b00};
          end else if (l4_idx == POS_W'(13)) begin
            cap.flags = data_byte[5:0];
          end
        end
        KIND_UDP: begin
          if (l4_idx < POS_W'(4)) begin
            cap.ports = {cur.ports[23:0], data_byte};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_offset   <= LINK_OFFSET_RESET;
      byte_position <= '0;
      cur           <= '0;
      snap_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        link_offset <= cfg_data;
      end
      if (accept) begin
        if (last_byte) begin
          byte_position <= '0;
          cur           <= '0;
        end else begin
          byte_position <= cap.total;
          cur           <= cap;
        end
      end
      if (accept && last_byte) begin
        snap_valid <= 1'b1;
      end else if (snap_adv) begin
        snap_valid <= 1'b0;
      end
      if (snap_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      snap <= cap;
    end
    if (snap_adv) begin
      res <= res_next;
    end
  end

  ipv4p_judge u_judge (
    .frame  (snap),
    .result (res_next)
  );

  assign status             = res.status;
  assign ip_version         = res.version;
  assign ip_header_bytes    = res.hdr_bytes;
  assign service_type       = res.service;
  assign fragment_offset    = res.fragment;
  assign src_address        = res.src_addr;
  assign dst_address        = res.dst_addr;
  assign port_pair          = res.ports;
  assign sequence_number    = res.seq;
  assign acknowledge_number = res.ack;
  assign tcp_flag_bits      = res.flags;
  assign payload_length     = res.payload;

endmodule
`default_nettype wire

// File: verif/ipv4_tcp_udp_header_parser_tb.sv
`timescale 1ns / 100ps

module ipv4_tcp_udp_header_parser_tb;
  import ipv4p_pkg::*;

  localparam int CYCLE_LIMIT = 50000;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [3:0]  ip_version;
  logic [5:0]  ip_header_bytes;
  logic [7:0]  service_type;
  logic [12:0] fragment_offset;
  logic [31:0] src_address;
  logic [31:0] dst_address;
  logic [31:0] port_pair;
  logic [31:0] sequence_number;
  logic [31:0] acknowledge_number;
  logic [5:0]  tcp_flag_bits;
  logic [15:0] payload_length;

  ipv4_tcp_udp_header_parser u_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .data_byte          (data_byte),
    .last_byte          (last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .ip_version         (ip_version),
    .ip_header_bytes    (ip_header_bytes),
    .service_type       (service_type),
    .fragment_offset    (fragment_offset),
    .src_address        (src_address),
    .dst_address        (dst_address),
    .port_pair          (port_pair),
    .sequence_number    (sequence_number),
    .acknowledge_number (acknowledge_number),
    .tcp_flag_bits      (tcp_flag_bits),
    .payload_length     (payload_length)
  );

  // parser model state
  logic [7:0]       link_off = LINK_OFFSET_RESET;
  logic [POS_W-1:0] frame_pos = '0;
  logic [5:0]       hdr_len = '0;
  kind_t            kind = KIND_NONE;
  logic [5:0]       tcp_len = '0;
  logic [3:0]       ip_ver = '0;
  logic [7:0]       tos = '0;
  logic [12:0]      frag = '0;
  logic [31:0]      src_ip = '0;
  logic [31:0]      dst_ip = '0;
  logic [31:0]      ports = '0;
  logic [31:0]      seq = '0;
  logic [31:0]      ack = '0;
  logic [5:0]       flags = '0;

  result_t     expected_q[$];
  logic [8:0]  byte_q[$];
  logic [7:0]  frame_buf[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  int          burst_left = 0;
  int          gap_left = 0;
  bit          gaps_on = 1'b1;
  logic [8:0]  next_beat;

  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_idx = 0;
  result_t     want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(input string what, input longint unsigned got,
                               input longint unsigned exp_val);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, exp_val);
    mismatch_cnt++;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic is_last);
    int unsigned i, j, total, rest, pay;
    status_t     st;
    result_t     r;
    bytes_taken++;
    if (frame_pos < MAX_FRAME_BYTES) begin
      if (frame_pos >= link_off) begin
        i = frame_pos - link_off;
        if (i == 0) begin
          ip_ver = b[7:4];
          hdr_len = {b[3:0], 2'b00};
        end else if (i == 1) tos = b;
        else if (i == 6) frag[12:8] = b[4:0];
        else if (i == 7) frag[7:0] = b;
        else if (i == 9)
          kind = (b == PROTO_TCP) ? KIND_TCP : (b == PROTO_UDP) ? KIND_UDP : KIND_NONE;
        else if (i >= 12 && i < 16) src_ip = {src_ip[23:0], b};
        else if (i >= 16 && i < 20) dst_ip = {dst_ip[23:0], b};
        if (hdr_len >= MIN_IP_BYTES && i >= hdr_len) begin
          j = i - hdr_len;
          if (kind == KIND_TCP) begin
            if (j < 4) ports = {ports[23:0], b};
            else if (j < 8) seq = {seq[23:0], b};
            else if (j < 12) ack = {ack[23:0], b};
            else if (j == 12) tcp_len = {b[7:4], 2'b00};
            else if (j == 13) flags = b[5:0];
          end else if (kind == KIND_UDP && j < 4) begin
            ports = {ports[23:0], b};
          end
        end
      end
      frame_pos = frame_pos + 1'b1;
    end
    if (is_last) begin
      total = frame_pos;
      pay = 0;
      if (total < link_off) st = ST_SHORT_LINK;
      else if (total - link_off < MIN_IP_BYTES) st = ST_SHORT_IP;
      else if (hdr_len < MIN_IP_BYTES) st = ST_BAD_IHL;
      else if (total - link_off < hdr_len) st = ST_SHORT_IP;
      else if (kind == KIND_NONE) st = ST_OTHER_PROTO;
      else begin
        rest = total - link_off - hdr_len;
        if (kind == KIND_TCP) begin
          if (rest < MIN_TCP_BYTES || rest < tcp_len) st = ST_SHORT_TCP;
          else begin
            pay = rest - tcp_len;
            st = ST_TCP_OK;
          end
        end else if (rest < UDP_BYTES) st = ST_SHORT_UDP;
        else begin
          pay = rest - UDP_BYTES;
          st = ST_UDP_OK;
        end
      end
      r = '0;
      r.status = st;
      if (st == ST_TCP_OK || st == ST_UDP_OK) begin
        r.version = ip_ver;
        r.hdr_bytes = hdr_len;
        r.service = tos;
        r.fragment = frag;
        r.src_addr = src_ip;
        r.dst_addr = dst_ip;
        r.ports = ports;
        if (st == ST_TCP_OK) begin
          r.seq = seq;
          r.ack = ack;
          r.flags = flags;
        end
        r.payload = (pay > PAYLOAD_MAX) ? PAYLOAD_MAX : pay[15:0];
      end
      expected_q.push_back(r);
      frame_pos = '0;
      hdr_len = '0;
      kind = KIND_NONE;
      tcp_len = '0;
      ip_ver = '0;
      tos = '0;
      frag = '0;
      src_ip = '0;
      dst_ip = '0;
      ports = '0;
      seq = '0;
      ack = '0;
      flags = '0;
    end
  endtask

  // byte driver: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        take_byte(data_byte, last_byte);
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || byte_q.size() == 0) begin
          if (gap_left > 0)
            gap_left--;
          in_valid <= 1'b0;
        end else begin
          next_beat = byte_q.pop_front();
          last_byte <= next_beat[8];
          data_byte <= next_beat[7:0];
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 47);
            gap_left = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
          end
        end
      end
    end
  end

  // result monitor, out_ready follows a rotating stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          note_mismatch("result beat with nothing expected, status", status, 0);
        end else begin
          want = expected_q.pop_front();
          if (status !== want.status) note_mismatch("status", status, want.status);
          if (ip_version !== want.version)
            note_mismatch("ip_version", ip_version, want.version);
          if (ip_header_bytes !== want.hdr_bytes)
            note_mismatch("ip_header_bytes", ip_header_bytes, want.hdr_bytes);
          if (service_type !== want.service)
            note_mismatch("service_type", service_type, want.service);
          if (fragment_offset !== want.fragment)
            note_mismatch("fragment_offset", fragment_offset, want.fragment);
          if (src_address !== want.src_addr)
            note_mismatch("src_address", src_address, want.src_addr);
          if (dst_address !== want.dst_addr)
            note_mismatch("dst_address", dst_address, want.dst_addr);
          if (port_pair !== want.ports) note_mismatch("port_pair", port_pair, want.ports);
          if (sequence_number !== want.seq)
            note_mismatch("sequence_number", sequence_number, want.seq);
          if (acknowledge_number !== want.ack)
            note_mismatch("acknowledge_number", acknowledge_number, want.ack);
          if (tcp_flag_bits !== want.flags)
            note_mismatch("tcp_flag_bits", tcp_flag_bits, want.flags);
          if (payload_length !== want.payload)
            note_mismatch("payload_length", payload_length, want.payload);
        end
      end
      if (pat_idx == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pat = 16'hFFFF;
          1: ready_pat = $urandom;
          2: ready_pat = $urandom | $urandom;
          default: ready_pat = $urandom & $urandom;
        endcase
      end
      out_ready <= ready_pat[pat_idx];
      pat_idx = (pat_idx + 1) % 16;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] fill_byte(input fill_t mode);
    logic [31:0] r;
    r = $urandom;
    case (mode)
      FILL_ONES:  return 8'hFF;
      FILL_ZEROS: return 8'h00;
      default:    return r[7:0];
    endcase
  endfunction

  task automatic build_frame(input int ihl, input logic [7:0] proto, input int doff,
                             input int pay_len, input fill_t mode);
    int         k, ip_bytes, tp_bytes;
    logic [7:0] v;
    frame_buf.delete();
    repeat (link_off) frame_buf.push_back(fill_byte(mode));
    ip_bytes = (ihl < 5 ? 5 : ihl) * 4;
    for (k = 0; k < ip_bytes; k++) begin
      v = fill_byte(mode);
      if (k == 0) v = {v[7:4], ihl[3:0]};
      if (k == 9) v = proto;
      frame_buf.push_back(v);
    end
    tp_bytes = (proto == PROTO_TCP) ? (doff < 5 ? 5 : doff) * 4 : 8;
    for (k = 0; k < tp_bytes; k++) begin
      v = fill_byte(mode);
      if (proto == PROTO_TCP && k == 12) v = {doff[3:0], v[3:0]};
      frame_buf.push_back(v);
    end
    repeat (pay_len) frame_buf.push_back(fill_byte(mode));
  endtask

  // cut > 0 truncates the frame to that many bytes
  task automatic send_frame(input int cut);
    int n, k;
    n = (cut > 0 && cut < frame_buf.size()) ? cut : frame_buf.size();
    for (k = 0; k < n; k++)
      byte_q.push_back({k == n - 1, frame_buf[k]});
    bytes_queued += n;
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || expected_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_offset(input logic [7:0] v);
    wait_idle();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    link_off = v;
    gaps_on = ($urandom_range(0, 3) != 0);
  endtask

  task automatic random_frames(input int min_bytes, input int min_frames);
    int         start, frames, ihl, doff, sel;
    logic [7:0] proto;
    start = bytes_queued;
    frames = 0;
    while (bytes_queued - start < min_bytes || frames < min_frames) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        frame_buf.delete();
        repeat ($urandom_range(1, 80)) frame_buf.push_back(fill_byte(FILL_RANDOM));
        send_frame(0);
      end else begin
        sel = $urandom_range(0, 99);
        ihl = (sel < 75) ? 5 : (sel < 95) ? $urandom_range(6, 15) : $urandom_range(0, 4);
        sel = $urandom_range(0, 99);
        proto = (sel < 50) ? PROTO_TCP : (sel < 88) ? PROTO_UDP : fill_byte(FILL_RANDOM);
        sel = $urandom_range(0, 99);
        doff = (sel < 80) ? 5 : (sel < 95) ? $urandom_range(6, 15) : $urandom_range(0, 4);
        build_frame(ihl, proto, doff, $urandom_range(0, 40), FILL_RANDOM);
        send_frame(($urandom_range(0, 99) < 15) ? $urandom_range(1, frame_buf.size()) : 0);
      end
      frames++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed frames at the reset link offset
    build_frame(5, PROTO_TCP, 5, 3, FILL_ONES);
    send_frame(0);
    build_frame(15, PROTO_TCP, 15, 0, FILL_ZEROS);
    send_frame(0);
    build_frame(5, PROTO_UDP, 5, 0, FILL_RANDOM);
    send_frame(0);
    build_frame(5, PROTO_UDP, 5, 5, FILL_ONES);
    send_frame(0);
    frame_buf.delete();
    frame_buf.push_back(fill_byte(FILL_RANDOM));
    send_frame(0);
    build_frame(5, PROTO_TCP, 5, 0, FILL_RANDOM);
    send_frame(13);
    send_frame(14);
    send_frame(14 + 19);
    build_frame(4, PROTO_TCP, 5, 0, FILL_RANDOM);
    send_frame(0);
    build_frame(0, PROTO_UDP, 5, 0, FILL_RANDOM);
    send_frame(0);
    build_frame(15, PROTO_TCP, 5, 0, FILL_RANDOM);
    send_frame(14 + 40);
    build_frame(5, 8'd1, 5, 6, FILL_RANDOM);
    send_frame(0);
    build_frame(5, PROTO_TCP, 5, 0, FILL_RANDOM);
    send_frame(14 + 20 + 19);
    build_frame(5, PROTO_TCP, 15, 0, FILL_RANDOM);
    send_frame(14 + 20 + 30);
    build_frame(5, PROTO_TCP, 0, 4, FILL_RANDOM);
    send_frame(0);
    build_frame(5, PROTO_UDP, 5, 0, FILL_RANDOM);
    send_frame(14 + 20 + 7);

    set_offset(8'd0);
    build_frame(5, PROTO_TCP, 5, 0, FILL_RANDOM);
    send_frame(0);
    random_frames(150, 2);

    set_offset(8'd255);
    build_frame(5, PROTO_TCP, 6, 2, FILL_RANDOM);
    send_frame(0);
    send_frame(200);

    set_offset(8'd14);
    random_frames(150, 2);

    set_offset(8'($urandom_range(1, 24)));
    random_frames(150, 2);

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
